/* design/slps_pkg.sv */
// ----------------------------------------------------------------------------
// slps_pkg: shared types and constants for the status LED pattern sequencer
// Mode codes, register indexes, reset values and the step tables.
// ----------------------------------------------------------------------------
package slps_pkg;

  typedef enum logic [1:0] {
    MODE_SOLID = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_AP    = 2'd2,
    MODE_WIFI  = 2'd3
  } mode_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SOLID_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MS    = 3'd5;

  localparam logic [7:0]  RST_SOLID_LEVEL = 8'd220;
  localparam logic [7:0]  RST_ON_LEVEL    = 8'd230;
  localparam logic [7:0]  RST_OFF_LEVEL   = 8'd255;
  localparam logic [15:0] RST_BLINK_MS    = 16'd500;
  localparam logic [15:0] RST_LONG_MS     = 16'd1000;
  localparam logic [15:0] RST_SHORT_MS    = 16'd200;

  localparam logic [2:0] BLINK_LEN = 3'd2;
  localparam logic [2:0] AP_LEN    = 3'd4;
  localparam logic [2:0] WIFI_LEN  = 3'd6;

  typedef struct packed {
    logic [7:0]  solid_level;
    logic [7:0]  on_level;
    logic [7:0]  off_level;
    logic [15:0] blink_ms;
    logic [15:0] long_ms;
    logic [15:0] short_ms;
  } cfg_t;

  // long step flags: AP is long, short, short, long
  function automatic logic ap_is_long(input logic [2:0] step);
    logic res;
    begin
      unique case (step)
        3'd0, 3'd3: res = 1'b1;
        default:    res = 1'b0;
      endcase
      return res;
    end
  endfunction

  // Wi-Fi is long, short, long, short, short, long
  function automatic logic wifi_is_long(input logic [2:0] step);
    logic res;
    begin
      unique case (step)
        3'd0, 3'd2, 3'd5: res = 1'b1;
        default:          res = 1'b0;
      endcase
      return res;
    end
  endfunction

endpackage

/* design/slps_item_if.sv */
// ----------------------------------------------------------------------------
// slps_item_if: update word channel
// Carries the current millisecond time and the requested mode.
// ----------------------------------------------------------------------------
interface slps_item_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [1:0]  mode;

  modport source (output valid, output now_ms, output mode, input ready);
  modport sink   (input valid, input now_ms, input mode, output ready);
endinterface

/* design/slps_result_if.sv */
// ----------------------------------------------------------------------------
// slps_result_if: LED level word channel
// Carries one LED drive level write.
// ----------------------------------------------------------------------------
interface slps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] led_level;

  modport source (output valid, output led_level, input ready);
  modport sink   (input valid, input led_level, output ready);
endinterface

/* design/slps_cfg_if.sv */
// ----------------------------------------------------------------------------
// slps_cfg_if: configuration write channel
// Register index plus write data.
// ----------------------------------------------------------------------------
interface slps_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [slps_pkg::CFG_IDX_W-1:0]    index;
  logic [slps_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/slps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// slps_cfg_regs: configuration register file
// Six level/duration registers; writes past the list are dropped.
// ----------------------------------------------------------------------------
module slps_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  slps_cfg_if.sink         cfg,
  output slps_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.solid_level <= slps_pkg::RST_SOLID_LEVEL;
      regs.on_level    <= slps_pkg::RST_ON_LEVEL;
      regs.off_level   <= slps_pkg::RST_OFF_LEVEL;
      regs.blink_ms    <= slps_pkg::RST_BLINK_MS;
      regs.long_ms     <= slps_pkg::RST_LONG_MS;
      regs.short_ms    <= slps_pkg::RST_SHORT_MS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        slps_pkg::REG_SOLID_LEVEL: regs.solid_level <= cfg.data[7:0];
        slps_pkg::REG_ON_LEVEL:    regs.on_level    <= cfg.data[7:0];
        slps_pkg::REG_OFF_LEVEL:   regs.off_level   <= cfg.data[7:0];
        slps_pkg::REG_BLINK_MS:    regs.blink_ms    <= cfg.data;
        slps_pkg::REG_LONG_MS:     regs.long_ms     <= cfg.data;
        slps_pkg::REG_SHORT_MS:    regs.short_ms    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

/* design/slps_step_core.sv */
// ----------------------------------------------------------------------------
// slps_step_core: pattern state and per-update step logic
// Holds mode, step and last-change time; at most one LED write per update.
// ----------------------------------------------------------------------------
module slps_step_core (
  input  logic                 clk,
  input  logic                 rst,
  input  slps_pkg::cfg_t       regs,
  input  logic                 en,
  input  logic [31:0]          now_ms,
  input  slps_pkg::mode_t      mode,
  output logic                 emit,
  output logic [7:0]           level
);

  slps_pkg::mode_t stored_mode;
  logic [2:0]      pattern_step;
  logic [31:0]     last_change_ms;

  logic [2:0]      pattern_step_next;
  logic [31:0]     last_change_ms_next;

  logic            changed;
  logic [2:0]      cur_step;
  logic [31:0]     cur_last;
  logic [2:0]      step;
  logic [2:0]      len;
  logic [15:0]     wait_ms;
  logic [31:0]     elapsed;
  logic            due;
  logic [2:0]      step_inc;

  always_comb begin
    changed  = (mode != stored_mode);
    cur_step = changed ? 3'd0 : pattern_step;
    cur_last = changed ? 32'd0 : last_change_ms;
    elapsed  = now_ms - cur_last;

    step    = cur_step;
    len     = slps_pkg::BLINK_LEN;
    wait_ms = regs.blink_ms;
    unique case (mode)
      slps_pkg::MODE_SOLID: begin
        len     = slps_pkg::BLINK_LEN;
        wait_ms = regs.blink_ms;
      end
      slps_pkg::MODE_BLINK: begin
        step    = {2'b00, cur_step[0]};
        len     = slps_pkg::BLINK_LEN;
        wait_ms = regs.blink_ms;
      end
      slps_pkg::MODE_AP: begin
        if (cur_step >= slps_pkg::AP_LEN) step = 3'd0;
        len     = slps_pkg::AP_LEN;
        wait_ms = slps_pkg::ap_is_long(step) ? regs.long_ms : regs.short_ms;
      end
      slps_pkg::MODE_WIFI: begin
        if (cur_step >= slps_pkg::WIFI_LEN) step = 3'd0;
        len     = slps_pkg::WIFI_LEN;
        wait_ms = slps_pkg::wifi_is_long(step) ? regs.long_ms : regs.short_ms;
      end
      default: ;
    endcase

    due      = (elapsed >= {16'd0, wait_ms});
    step_inc = step + 3'd1;
    if (step_inc >= len) step_inc = 3'd0;

    if (mode == slps_pkg::MODE_SOLID) begin
      emit                = 1'b1;
      level               = regs.solid_level;
      pattern_step_next   = cur_step;
      last_change_ms_next = cur_last;
    end else if (due) begin
      emit                = 1'b1;
      level               = step[0] ? regs.off_level : regs.on_level;
      pattern_step_next   = step_inc;
      last_change_ms_next = now_ms;
    end else begin
      emit                = 1'b0;
      level               = regs.on_level;
      pattern_step_next   = cur_step;
      last_change_ms_next = cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_mode    <= slps_pkg::MODE_SOLID;
      pattern_step   <= 3'd0;
      last_change_ms <= 32'd0;
    end else if (en) begin
      stored_mode    <= mode;
      pattern_step   <= pattern_step_next;
      last_change_ms <= last_change_ms_next;
    end
  end

endmodule

/* design/status_led_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer: status LED blink/pattern sequencer
// One update word in, zero or one LED level word out.
// ----------------------------------------------------------------------------
// Usage:
//   item   - update words: now_ms (free-running ms time) and mode
//            (solid, blink, AP pattern, Wi-Fi pattern).
//   result - LED level words; one per update in solid mode, otherwise one
//            each time the current pattern step's duration has passed.
//   cfg    - register writes (levels and step durations), always ready;
//            write only while no update is in flight.
// Timing: an update is captured in the input register, evaluated by the
//   step logic while it is held there, and its LED word is registered in the
//   result register when the update advances. One update per cycle is
//   accepted at full rate, while the result side does not stall.
// Stall: while result is held, the input register keeps its word and
//   item.ready drops only when that register is full and cannot drain.
// Reset: solid mode, step 0, last-change time 0, registers to defaults;
//   no word is pending after reset.
// ----------------------------------------------------------------------------
module status_led_pattern_sequencer (
  input  logic           clk,
  input  logic           rst,
  slps_item_if.sink      item,
  slps_result_if.source  result,
  slps_cfg_if.sink       cfg
);

  slps_pkg::cfg_t regs;

  // input register
  logic                 in_valid;
  logic [31:0]          in_now_ms;
  slps_pkg::mode_t      in_mode;

  // result register
  logic                 out_valid;
  logic [7:0]           out_level;

  logic                 advance;
  logic                 emit;
  logic [7:0]           level;

  slps_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // evaluate the held update once the result register has room
  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  slps_step_core u_step_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .en     (advance),
    .now_ms (in_now_ms),
    .mode   (in_mode),
    .emit   (emit),
    .level  (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_now_ms <= item.now_ms;
      in_mode   <= slps_pkg::mode_t'(item.mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_level <= level;
    end
  end

  assign result.valid     = out_valid;
  assign result.led_level = out_level;

endmodule

/* verif/tb_status_led_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_status_led_pattern_sequencer: self-checking bench for the LED sequencer
// Drives update words (time, mode) and register writes into the block. A
// scoreboard class keeps its own copy of the mode, step and timing state,
// predicts each LED level word, and checks the words that come out in order.
// ----------------------------------------------------------------------------
module tb_status_led_pattern_sequencer;

  // --------------------------------------------------------------------------
  // Scoreboard: sequencer state, register copy and the queue of LED levels
  // that still have to come out of the block.
  // --------------------------------------------------------------------------
  class led_level_scoreboard;
    logic [7:0]  solid_level;
    logic [7:0]  on_level;
    logic [7:0]  off_level;
    logic [15:0] blink_ms;
    logic [15:0] long_ms;
    logic [15:0] short_ms;

    slps_pkg::mode_t cur_mode;
    logic [2:0]      step;
    logic [31:0]     last_ms;

    logic [7:0]  pending_levels[$];
    int unsigned errors;
    int unsigned words_checked;

    function new();
      solid_level   = slps_pkg::RST_SOLID_LEVEL;
      on_level      = slps_pkg::RST_ON_LEVEL;
      off_level     = slps_pkg::RST_OFF_LEVEL;
      blink_ms      = slps_pkg::RST_BLINK_MS;
      long_ms       = slps_pkg::RST_LONG_MS;
      short_ms      = slps_pkg::RST_SHORT_MS;
      cur_mode      = slps_pkg::MODE_SOLID;
      step          = '0;
      last_ms       = '0;
      errors        = 0;
      words_checked = 0;
    endfunction

    // Register write; level registers keep only the low byte.
    function void write_reg(logic [slps_pkg::CFG_IDX_W-1:0]  idx,
                            logic [slps_pkg::CFG_DATA_W-1:0] data);
      unique case (idx)
        slps_pkg::REG_SOLID_LEVEL: solid_level = data[7:0];
        slps_pkg::REG_ON_LEVEL:    on_level    = data[7:0];
        slps_pkg::REG_OFF_LEVEL:   off_level   = data[7:0];
        slps_pkg::REG_BLINK_MS:    blink_ms    = data;
        slps_pkg::REG_LONG_MS:     long_ms     = data;
        slps_pkg::REG_SHORT_MS:    short_ms    = data;
        default: ;
      endcase
    endfunction

    // One accepted update word: advance the sequencer, queue a level if due.
    function void note_update(logic [31:0] now, slps_pkg::mode_t md);
      logic [31:0] elapsed;
      logic [31:0] hold_ms;
      logic [2:0]  st;
      logic [2:0]  len;
      if (md != cur_mode) begin
        cur_mode = md;
        last_ms  = '0;
        step     = '0;
      end
      if (cur_mode == slps_pkg::MODE_SOLID) begin
        pending_levels.push_back(solid_level);
        return;
      end
      elapsed = now - last_ms;
      st      = step;
      unique case (cur_mode)
        slps_pkg::MODE_BLINK: begin
          st      = {2'b00, st[0]};
          len     = 3'd2;
          hold_ms = blink_ms;
        end
        slps_pkg::MODE_AP: begin
          len = 3'd4;
          if (st >= len) st = '0;
          // long, short, short, long
          hold_ms = (st == 3'd0 || st == 3'd3) ? long_ms : short_ms;
        end
        default: begin
          len = 3'd6;
          if (st >= len) st = '0;
          // long, short, long, short, short, long
          hold_ms = (st == 3'd0 || st == 3'd2 || st == 3'd5) ? long_ms : short_ms;
        end
      endcase
      if (elapsed < hold_ms) return;
      pending_levels.push_back(st[0] ? off_level : on_level);
      st = st + 3'd1;
      if (st >= len) st = '0;
      step    = st;
      last_ms = now;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("  mismatch: %s", msg);
    endfunction

    // One accepted LED word against the oldest prediction.
    function void check_level(logic [7:0] actual);
      logic [7:0] exp_level;
      words_checked++;
      if (pending_levels.size() == 0) begin
        report($sformatf("unexpected led_level %0d", actual));
        return;
      end
      exp_level = pending_levels.pop_front();
      if (actual !== exp_level)
        report($sformatf("led_level expected %0d got %0d", exp_level, actual));
    endfunction

    // Anything still queued at the end never came out.
    function void close();
      if (pending_levels.size() != 0)
        report($sformatf("%0d LED words never arrived", pending_levels.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  slps_item_if   item_ch();
  slps_result_if level_ch();
  slps_cfg_if    cfg_ch();

  status_led_pattern_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (level_ch),
    .cfg    (cfg_ch)
  );

  led_level_scoreboard sb;

  // idling knobs; both are turned off for the closing phase
  bit          sender_idle;
  bit          sink_idle;
  // long receiver hold-off, counted down by the sink process
  int unsigned stall_hold;

  // sender-side time and mode track, so sequences stay well formed
  logic [31:0]     t_now;
  slps_pkg::mode_t t_mode;
  logic [15:0]     span_ms;

  int unsigned n_updates;
  int unsigned n_writes;
  int unsigned n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far above the slowest legal run (~450 words, each with random
  // idling on both sides, plus one long hold-off).
  initial begin
    #2_000_000;
    $display("tb_status_led_pattern_sequencer: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // LED word sink: checks each accepted word, drives ready with random stall
  // bursts and the one long hold-off. Sampling right after the edge sees the
  // pre-edge values, so valid/ready here are what the block saw.
  // --------------------------------------------------------------------------
  initial begin : level_sink
    int unsigned gap;
    gap = 0;
    level_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && level_ch.valid && level_ch.ready)
        sb.check_level(level_ch.led_level);
      if (stall_hold > 0) begin
        stall_hold--;
        level_ch.ready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        level_ch.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        // start a stall burst; gap holds the rest of it
        gap = $urandom_range(0, 9);
        level_ch.ready <= 1'b0;
      end else begin
        level_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All run from a rising edge and leave valid high after an
  // accepted word, so back-to-back words never drop valid in between.
  // --------------------------------------------------------------------------
  task automatic send_update(input logic [31:0] now, input slps_pkg::mode_t md);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item_ch.valid  <= 1'b1;
    item_ch.now_ms <= now;
    item_ch.mode   <= md;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_update(now, md);
    n_updates++;
  endtask

  task automatic cfg_write(input logic [slps_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [slps_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    n_writes++;
  endtask

  // Full register load. Level writes carry random junk in the upper byte,
  // which the block must drop.
  task automatic load_regs(input logic [7:0] solid, input logic [7:0] on_lv,
                           input logic [7:0] off_lv, input logic [15:0] blink,
                           input logic [15:0] lng, input logic [15:0] shrt);
    cfg_write(slps_pkg::REG_SOLID_LEVEL, {8'($urandom), solid});
    cfg_write(slps_pkg::REG_ON_LEVEL,    {8'($urandom), on_lv});
    cfg_write(slps_pkg::REG_OFF_LEVEL,   {8'($urandom), off_lv});
    cfg_write(slps_pkg::REG_BLINK_MS,    blink);
    cfg_write(slps_pkg::REG_LONG_MS,     lng);
    cfg_write(slps_pkg::REG_SHORT_MS,    shrt);
    cfg_ch.valid <= 1'b0;
    // time steps for the random track scale with the longest duration
    span_ms = blink;
    if (lng > span_ms)  span_ms = lng;
    if (shrt > span_ms) span_ms = shrt;
    n_settings++;
  endtask

  // Drop valid, wait for every predicted word, then let the pipe settle:
  // an update that gives no word may still sit in the input register.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random part: mostly one mode held with time moving forward in steps on
  // the order of the durations, so patterns run through all their steps.
  // Some mode switches, time going backwards, and fully random words.
  task automatic run_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        t_now  = $urandom;
        t_mode = slps_pkg::mode_t'($urandom_range(0, 3));
      end else if (r < 9) begin
        t_now = t_now - $urandom_range(1, 100);
      end else if (r < 18) begin
        t_mode = slps_pkg::mode_t'($urandom_range(0, 3));
        t_now  = t_now + $urandom_range(0, span_ms);
      end else begin
        t_now = t_now + $urandom_range(0, 2 * span_ms + 1);
      end
      send_update(t_now, t_mode);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb          = new();
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    stall_hold  = 0;
    n_updates   = 0;
    n_writes    = 0;
    n_settings  = 0;
    span_ms     = slps_pkg::RST_LONG_MS;

    rst            <= 1'b1;
    item_ch.valid  <= 1'b0;
    item_ch.now_ms <= '0;
    item_ch.mode   <= slps_pkg::MODE_SOLID;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= slps_pkg::REG_SOLID_LEVEL;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset register values.
    // Solid at both ends of the time range.
    send_update(32'h0000_0000, slps_pkg::MODE_SOLID);
    send_update(32'hFFFF_FFFF, slps_pkg::MODE_SOLID);
    // Blink: entering the mode clears the last-change time; just under and
    // exactly at the half period, then the toggle back.
    send_update(32'd0,    slps_pkg::MODE_BLINK);
    send_update(32'd499,  slps_pkg::MODE_BLINK);
    send_update(32'd500,  slps_pkg::MODE_BLINK);
    send_update(32'd999,  slps_pkg::MODE_BLINK);
    send_update(32'd1000, slps_pkg::MODE_BLINK);
    send_update(32'd1500, slps_pkg::MODE_BLINK);
    // AP: long, short, short, long and the wrap back to step 0
    send_update(32'd1000, slps_pkg::MODE_AP);
    send_update(32'd1100, slps_pkg::MODE_AP);
    send_update(32'd1200, slps_pkg::MODE_AP);
    send_update(32'd1400, slps_pkg::MODE_AP);
    send_update(32'd2400, slps_pkg::MODE_AP);
    send_update(32'd3400, slps_pkg::MODE_AP);
    // Wi-Fi across the 2^32 wrap of the millisecond counter
    send_update(32'hFFFF_FFFF, slps_pkg::MODE_WIFI);
    send_update(32'h0000_00C7, slps_pkg::MODE_WIFI);
    send_update(32'h0000_04AE, slps_pkg::MODE_WIFI);
    send_update(32'h0000_04AF, slps_pkg::MODE_WIFI);
    send_update(32'h0000_0577, slps_pkg::MODE_WIFI);
    send_update(32'h0000_095F, slps_pkg::MODE_WIFI);
    send_update(32'h0000_0A27, slps_pkg::MODE_WIFI);
    send_update(32'h0000_0AEF, slps_pkg::MODE_WIFI);
    send_update(32'h0000_0ED7, slps_pkg::MODE_WIFI);
    // and back to solid
    send_update(32'h0000_0ED8, slps_pkg::MODE_SOLID);
    drain();

    t_now  = 32'd0;
    t_mode = slps_pkg::MODE_BLINK;

    // Zero durations: every pattern step fires on every update.
    load_regs(8'd0, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0);
    run_random(60);
    drain();

    // Longest durations, levels flipped.
    load_regs(8'd255, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(60);
    drain();

    // Short durations; the receiver holds off long enough that the block
    // fills and pushes back on the sender.
    load_regs(8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
              16'($urandom_range(1, 60)));
    stall_hold = 250;
    run_random(60);
    drain();

    // A stretch with no idling on either side.
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    load_regs(8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
              16'($urandom_range(0, 30)));
    run_random(60);
    drain();

    // Wide random durations, time track starting just short of the wrap.
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    load_regs(8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
    t_now = 32'hFFF0_0000;
    run_random(60);
    drain();

    load_regs(8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom_range(1, 25)), 16'($urandom_range(1, 25)),
              16'($urandom_range(1, 25)));
    run_random(60);
    drain();

    // Closing phase: back to the power-up settings, full rate both sides.
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    load_regs(slps_pkg::RST_SOLID_LEVEL, slps_pkg::RST_ON_LEVEL,
              slps_pkg::RST_OFF_LEVEL, slps_pkg::RST_BLINK_MS,
              slps_pkg::RST_LONG_MS, slps_pkg::RST_SHORT_MS);
    run_random(60);
    drain();

    sb.close();
    $display("Covered %0d updates in all four modes over %0d register settings",
             n_updates, n_settings + 1);
    $display("(%0d register writes), %0d LED words checked, %0d mismatches.",
             n_writes, sb.words_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_status_led_pattern_sequencer: PASS");
    end else begin
      $display("tb_status_led_pattern_sequencer: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/slps_pkg.sv
design/slps_item_if.sv
design/slps_result_if.sv
design/slps_cfg_if.sv
design/slps_cfg_regs.sv
design/slps_step_core.sv
design/status_led_pattern_sequencer.sv
verif/tb_status_led_pattern_sequencer.sv
